/* sv/prp_pkg.sv */
// Package for the page replacement engine: sequencer states, policy, status
// and register index codes, and default parameter values.
// No dependencies.
package prp_pkg;

    localparam int NUM_PAGES_DEF = 16;
    localparam int TIME_BITS_DEF = 32;

    localparam int FRAME_W    = 5;
    localparam int POLICY_W   = 2;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 5;
    localparam int PAGE_IN_W  = 8;
    localparam int NEXT_USE_W = 32;
    localparam int STATUS_W   = 2;
    localparam int VICTIM_W   = 4;

    localparam logic [FRAME_W-1:0] FRAME_COUNT_RST = 5'd4;

    localparam logic [CFG_IDX_W-1:0] REG_FRAME_COUNT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_POLICY      = 1'b1;

    localparam logic [POLICY_W-1:0] POL_FIFO = 2'd0;
    localparam logic [POLICY_W-1:0] POL_LRU  = 2'd1;
    localparam logic [POLICY_W-1:0] POL_OPT  = 2'd2;

    localparam logic [STATUS_W-1:0] STAT_HIT     = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_FAULT   = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_INVALID = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECIDE,
        ST_SCAN,
        ST_UPDATE,
        ST_RESP
    } prp_state_t;

endpackage

/* sv/page_replacement_policy.sv */
// Sequence: an invalid page goes from DECIDE to RESP; a hit or a fault into a free frame passes
// DECIDE, UPDATE and RESP; a fault that evicts adds a stamp SCAN (one entry a cycle) before UPDATE.
// One transaction at a time: the next can be taken in the cycle after the result is registered.
// Reset clears residency, occupancy and time; the stamp memory needs no clearing pass.
// Depends on prp_pkg.
module page_replacement_policy
    import prp_pkg::*;
#(
    parameter int NUM_PAGES = NUM_PAGES_DEF,
    parameter int TIME_BITS = TIME_BITS_DEF
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_we,
    input  logic [CFG_IDX_W-1:0]    cfg_index,
    input  logic [CFG_DATA_W-1:0]   cfg_data,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic [PAGE_IN_W-1:0]    page,
    input  logic [NEXT_USE_W-1:0]   next_use,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic [STATUS_W-1:0]     status,
    output logic [VICTIM_W-1:0]     victim,
    output logic                    victim_valid
);

    localparam int PAGE_W = (NUM_PAGES > 1) ? $clog2(NUM_PAGES) : 1;
    localparam int SCAN_W = $clog2(NUM_PAGES + 1);
    localparam int CNT_W  = ($clog2(NUM_PAGES + 1) > FRAME_W) ? $clog2(NUM_PAGES + 1) : FRAME_W;
    localparam logic [SCAN_W-1:0] SCAN_END = SCAN_W'(NUM_PAGES);
    localparam logic [CNT_W-1:0]  NP_CNT   = CNT_W'(NUM_PAGES);

    prp_state_t state_reg, state_next;

    logic [FRAME_W-1:0]   frame_count_reg;
    logic [POLICY_W-1:0]  policy_reg;
    logic [NUM_PAGES-1:0] resident_reg, resident_next;
    logic [CNT_W-1:0]     frames_used_reg, frames_used_next;
    logic [TIME_BITS-1:0] time_reg;

    logic [PAGE_W-1:0]    page_reg;
    logic                 page_ok_reg;
    logic [TIME_BITS-1:0] nu_reg;
    logic [TIME_BITS-1:0] now_reg;
    logic                 hit_reg;

    logic [SCAN_W-1:0]    scan_cnt_reg;
    logic                 cmp_vld_reg;
    logic [PAGE_W-1:0]    cmp_idx_reg;
    logic [TIME_BITS-1:0] best_reg;
    logic [PAGE_W-1:0]    best_idx_reg;
    logic                 best_vld_reg;

    logic [STATUS_W-1:0]  res_status_reg, res_status_next;
    logic [VICTIM_W-1:0]  res_victim_reg, res_victim_next;
    logic                 res_vv_reg, res_vv_next;

    logic                 out_valid_reg;
    logic [STATUS_W-1:0]  status_reg;
    logic [VICTIM_W-1:0]  victim_reg;
    logic                 victim_valid_reg;

    logic [TIME_BITS-1:0] stamp_mem [NUM_PAGES];
    logic [TIME_BITS-1:0] rd_data_reg;
    logic [PAGE_W-1:0]    rd_addr;
    logic                 mem_we;
    logic [TIME_BITS-1:0] mem_wdata;

    logic                 accept;
    logic                 is_lru;
    logic                 is_opt;
    logic [CNT_W-1:0]     fc_ext;
    logic [CNT_W-1:0]     eff_frames;
    logic                 need_evict;
    logic                 scan_done;
    logic                 stamp_lt;
    logic                 take;
    logic                 resp_load;

    assign accept    = in_valid && in_ready;
    assign is_lru    = (policy_reg == POL_LRU);
    assign is_opt    = (policy_reg == POL_OPT);
    assign fc_ext    = CNT_W'(frame_count_reg);
    assign scan_done = (scan_cnt_reg == SCAN_END);
    assign resp_load = (state_reg == ST_RESP) && (!out_valid_reg || out_ready);

    always_comb
    begin
        if (fc_ext == '0)
        begin
            eff_frames = CNT_W'(1);
        end
        else if (fc_ext > NP_CNT)
        begin
            eff_frames = NP_CNT;
        end
        else
        begin
            eff_frames = fc_ext;
        end
    end

    assign need_evict = (frames_used_reg >= eff_frames);

    // Shared compare unit: one stamp against the running best per cycle.
    assign stamp_lt = (rd_data_reg < best_reg);
    assign take     = cmp_vld_reg && resident_reg[cmp_idx_reg] &&
                      (!best_vld_reg || (is_opt ? !stamp_lt : stamp_lt));

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE:
            begin
                if (!page_ok_reg)
                begin
                    state_next = ST_RESP;
                end
                else if (resident_reg[page_reg] || !need_evict)
                begin
                    state_next = ST_UPDATE;
                end
                else
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (scan_done)
                begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE:
            begin
                state_next = ST_RESP;
            end
            ST_RESP:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_ready         = 1'b0;
        mem_we           = 1'b0;
        mem_wdata        = is_opt ? nu_reg : now_reg;
        rd_addr          = scan_cnt_reg[PAGE_W-1:0];
        resident_next    = resident_reg;
        frames_used_next = frames_used_reg;
        res_status_next  = res_status_reg;
        res_victim_next  = res_victim_reg;
        res_vv_next      = res_vv_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
            end
            ST_DECIDE:
            begin
                res_victim_next = '0;
                res_vv_next     = 1'b0;
                if (!page_ok_reg)
                begin
                    res_status_next = STAT_INVALID;
                end
                else if (resident_reg[page_reg])
                begin
                    res_status_next = STAT_HIT;
                end
                else
                begin
                    res_status_next = STAT_FAULT;
                end
            end
            ST_SCAN:
            begin
            end
            ST_UPDATE:
            begin
                if (hit_reg)
                begin
                    mem_we = is_lru || is_opt;
                end
                else
                begin
                    mem_we = 1'b1;
                    if (best_vld_reg)
                    begin
                        resident_next[best_idx_reg] = 1'b0;
                        res_victim_next             = VICTIM_W'(best_idx_reg);
                        res_vv_next                 = 1'b1;
                    end
                    else
                    begin
                        frames_used_next = frames_used_reg + CNT_W'(1);
                    end
                    resident_next[page_reg] = 1'b1;
                end
            end
            ST_RESP:
            begin
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            frame_count_reg  <= FRAME_COUNT_RST;
            policy_reg       <= POL_FIFO;
            resident_reg     <= '0;
            frames_used_reg  <= '0;
            time_reg         <= '0;
            scan_cnt_reg     <= '0;
            cmp_vld_reg      <= 1'b0;
            best_vld_reg     <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            resident_reg    <= resident_next;
            frames_used_reg <= frames_used_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_FRAME_COUNT: frame_count_reg <= cfg_data[FRAME_W-1:0];
                    REG_POLICY:      policy_reg      <= cfg_data[POLICY_W-1:0];
                    default:
                    begin
                    end
                endcase
            end
            if (accept)
            begin
                time_reg <= time_reg + TIME_BITS'(1);
            end
            if (state_reg == ST_DECIDE)
            begin
                scan_cnt_reg <= '0;
                best_vld_reg <= 1'b0;
            end
            else if (state_reg == ST_SCAN && !scan_done)
            begin
                scan_cnt_reg <= scan_cnt_reg + SCAN_W'(1);
            end
            if (take)
            begin
                best_vld_reg <= 1'b1;
            end
            cmp_vld_reg <= (state_reg == ST_SCAN) && !scan_done;
            if (resp_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            page_reg    <= page[PAGE_W-1:0];
            page_ok_reg <= (int'(page) < NUM_PAGES);
            nu_reg      <= TIME_BITS'(next_use);
            now_reg     <= time_reg;
        end
        if (state_reg == ST_DECIDE)
        begin
            hit_reg <= resident_reg[page_reg];
        end
        cmp_idx_reg <= scan_cnt_reg[PAGE_W-1:0];
        if (take)
        begin
            best_reg     <= rd_data_reg;
            best_idx_reg <= cmp_idx_reg;
        end
        res_status_reg <= res_status_next;
        res_victim_reg <= res_victim_next;
        res_vv_reg     <= res_vv_next;
        if (resp_load)
        begin
            status_reg       <= res_status_reg;
            victim_reg       <= res_victim_reg;
            victim_valid_reg <= res_vv_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            stamp_mem[page_reg] <= mem_wdata;
        end
        rd_data_reg <= stamp_mem[rd_addr];
    end

    assign out_valid    = out_valid_reg;
    assign status       = status_reg;
    assign victim       = victim_reg;
    assign victim_valid = victim_valid_reg;

    // Occupancy always equals the number of resident pages.
    assert property (@(posedge clk) disable iff (!rst_n)
        $countones(resident_reg) == int'(frames_used_reg))
        else $error("frames_used does not match the resident count");

    assert property (@(posedge clk) disable iff (!rst_n)
        frames_used_reg <= NP_CNT)
        else $error("frames_used exceeds the page count");

    // A full table always holds at least one resident page, so a scan finds a victim.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN && scan_done) |=> best_vld_reg)
        else $error("victim scan ended without a candidate");

    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && victim_valid_reg) |-> (status_reg == STAT_FAULT))
        else $error("victim reported on a transaction that is not a fault");

endmodule

/* verif/tb_page_replacement_policy.sv */
`timescale 1ns / 1ps
// Testbench for page_replacement_policy: directed and random page-reference streams
// under FIFO, LRU, OPT and the spare policy code, each result checked against a behavioral page-table model.
// Depends on prp_pkg and the page_replacement_policy RTL.
module tb_page_replacement_policy
    import prp_pkg::*;
();

    localparam int PAGES = NUM_PAGES_DEF;
    localparam int PAGE_IDX_W = $clog2(PAGES);
    localparam int DRAIN_CYCLES = PAGES + 10;
    localparam logic [POLICY_W-1:0] POL_SPARE = 2'd3;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [VICTIM_W-1:0] victim;
        logic                victim_valid;
    } access_outcome_t;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  in_valid;
    logic                  in_ready;
    logic [PAGE_IN_W-1:0]  page;
    logic [NEXT_USE_W-1:0] next_use;
    logic                  out_valid;
    logic                  out_ready;
    logic [STATUS_W-1:0]   status;
    logic [VICTIM_W-1:0]   victim;
    logic                  victim_valid;

    bit                       tbl_resident [PAGES];
    bit [FRAME_W-1:0]         tbl_used;
    bit [TIME_BITS_DEF-1:0]   tbl_stamp [PAGES];
    bit [TIME_BITS_DEF-1:0]   tbl_clock;
    bit [FRAME_W-1:0]         tbl_frames;
    bit [POLICY_W-1:0]        tbl_policy;

    access_outcome_t pending_outcomes[$];
    int errors;
    int send_idle_pct;
    int recv_stall_pct;

    page_replacement_policy dut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .page         (page),
        .next_use     (next_use),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .status       (status),
        .victim       (victim),
        .victim_valid (victim_valid)
    );

    always #5 clk = ~clk;

    function automatic void clear_page_table();
        for (int p = 0; p < PAGES; p++)
        begin
            tbl_resident[p] = 1'b0;
            tbl_stamp[p] = '0;
        end
        tbl_used = '0;
        tbl_clock = '0;
        tbl_frames = FRAME_COUNT_RST;
        tbl_policy = POL_FIFO;
    endfunction

    function automatic access_outcome_t resolve_access(input logic [PAGE_IN_W-1:0] pg,
                                                       input logic [NEXT_USE_W-1:0] nu);
        access_outcome_t res;
        bit [TIME_BITS_DEF-1:0] now;
        bit opt;
        int limit;
        int best;
        logic [PAGE_IDX_W-1:0] pidx;
        res = '0;
        now = tbl_clock;
        opt = (tbl_policy == POL_OPT);
        pidx = pg[PAGE_IDX_W-1:0];
        tbl_clock = tbl_clock + TIME_BITS_DEF'(1);
        limit = (tbl_frames == '0) ? 1
                : ((int'(tbl_frames) > PAGES) ? PAGES : int'(tbl_frames));
        if (int'(pg) >= PAGES)
        begin
            res.status = STAT_INVALID;
        end
        else if (tbl_resident[pidx])
        begin
            res.status = STAT_HIT;
            if (tbl_policy == POL_LRU)
                tbl_stamp[pidx] = now;
            else if (opt)
                tbl_stamp[pidx] = nu;
        end
        else
        begin
            res.status = STAT_FAULT;
            best = -1;
            if (int'(tbl_used) >= limit)
            begin
                for (int p = 0; p < PAGES; p++)
                begin
                    if (tbl_resident[p])
                    begin
                        if (best < 0)
                            best = p;
                        else if (opt ? (tbl_stamp[p] >= tbl_stamp[best])
                                     : (tbl_stamp[p] < tbl_stamp[best]))
                            best = p;
                    end
                end
            end
            if (best >= 0)
            begin
                tbl_resident[best] = 1'b0;
                res.victim = VICTIM_W'(best);
                res.victim_valid = 1'b1;
            end
            else
            begin
                tbl_used = tbl_used + FRAME_W'(1);
            end
            tbl_resident[pidx] = 1'b1;
            tbl_stamp[pidx] = opt ? nu : now;
        end
        return res;
    endfunction

    task automatic send_access(input logic [PAGE_IN_W-1:0] pg, input logic [NEXT_USE_W-1:0] nu);
        if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < send_idle_pct);
        end
        in_valid <= 1'b1;
        page <= pg;
        next_use <= nu;
        do
            @(posedge clk);
        while (!in_ready);
        pending_outcomes.push_back(resolve_access(pg, nu));
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_outcomes.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == REG_FRAME_COUNT)
            tbl_frames = val;
        else
            tbl_policy = val[POLICY_W-1:0];
        @(posedge clk);
    endtask

    always @(posedge clk)
    begin
        out_ready <= (recv_stall_pct == 0) || ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge clk)
    begin : check_outcomes
        access_outcome_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_outcomes.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected transaction: status %0d victim %0d victim_valid %0b",
                         $time, status, victim, victim_valid);
            end
            else
            begin
                want = pending_outcomes.pop_front();
                if (status !== want.status)
                begin
                    errors++;
                    $display("%0t: status expected %0d actual %0d", $time, want.status, status);
                end
                if (victim !== want.victim)
                begin
                    errors++;
                    $display("%0t: victim expected %0d actual %0d", $time, want.victim, victim);
                end
                if (victim_valid !== want.victim_valid)
                begin
                    errors++;
                    $display("%0t: victim_valid expected %0b actual %0b",
                             $time, want.victim_valid, victim_valid);
                end
            end
        end
    end

    task automatic test_fifo_basics();
        write_reg(REG_FRAME_COUNT, FRAME_COUNT_RST);
        write_reg(REG_POLICY, CFG_DATA_W'(POL_FIFO));
        send_access(8'd0, 32'h0000_0000);
        send_access(8'd1, $urandom);
        send_access(8'd2, $urandom);
        send_access(8'd3, $urandom);
        send_access(8'd0, $urandom);
        send_access(8'd4, $urandom);
        send_access(8'd255, 32'hFFFF_FFFF);
        send_access(8'd16, $urandom);
        send_access(8'd128, $urandom);
        send_access(8'd15, $urandom);
        wait_idle();
    endtask

    task automatic test_lru_over_fifo_stamps();
        write_reg(REG_POLICY, CFG_DATA_W'(POL_LRU));
        send_access(8'd2, $urandom);
        send_access(8'd14, $urandom);
        wait_idle();
    endtask

    task automatic test_opt_ties_and_shrink();
        write_reg(REG_POLICY, CFG_DATA_W'(POL_OPT));
        send_access(8'd2, 32'hFFFF_FFFF);
        send_access(8'd4, 32'hFFFF_FFFF);
        wait_idle();
        write_reg(REG_FRAME_COUNT, 5'd0);
        send_access(8'd7, 32'd5);
        send_access(8'd9, 32'd0);
        wait_idle();
    endtask

    task automatic test_spare_codes();
        write_reg(REG_POLICY, CFG_DATA_W'(POL_SPARE));
        write_reg(REG_FRAME_COUNT, 5'd31);
        send_access(8'd5, $urandom);
        send_access(8'd6, $urandom);
        send_access(8'd10, $urandom);
        send_access(8'd5, $urandom);
        wait_idle();
    endtask

    task automatic test_random_streams();
        int phase_idle[4] = '{0, 81, 0, 16};
        int phase_stall[4] = '{0, 0, 81, 16};
        int frame_pick[6] = '{1, PAGES, 0, 31, 4, 8};
        int seg_len;
        int base;
        int width;
        int nxt;
        bit well_formed;
        logic [PAGE_IN_W-1:0] stream[$];
        logic [NEXT_USE_W-1:0] nu;
        for (int ph = 0; ph < 4; ph++)
        begin
            for (int seg = 0; seg < 8; seg++)
            begin
                wait_idle();
                send_idle_pct = phase_idle[ph];
                recv_stall_pct = phase_stall[ph];
                write_reg(REG_FRAME_COUNT,
                          CFG_DATA_W'((seg < 6) ? frame_pick[seg] : $urandom_range(31)));
                write_reg(REG_POLICY, CFG_DATA_W'($urandom_range(3)));
                seg_len = $urandom_range(36, 60);
                well_formed = ($urandom_range(99) < 80);
                base = $urandom_range(PAGES - 1);
                width = $urandom_range(1, PAGES);
                stream.delete();
                for (int i = 0; i < seg_len; i++)
                begin
                    if ($urandom_range(99) < 5)
                        stream.push_back(PAGE_IN_W'($urandom_range(255, PAGES)));
                    else
                        stream.push_back(PAGE_IN_W'((base + $urandom_range(width - 1)) % PAGES));
                end
                for (int i = 0; i < seg_len; i++)
                begin
                    if (well_formed)
                    begin
                        nxt = seg_len;
                        for (int j = seg_len - 1; j > i; j--)
                        begin
                            if (stream[j] == stream[i])
                                nxt = j;
                        end
                        nu = NEXT_USE_W'(nxt);
                    end
                    else
                    begin
                        nu = $urandom;
                    end
                    send_access(stream[i], nu);
                end
            end
        end
        send_idle_pct = 0;
        recv_stall_pct = 0;
    endtask

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = REG_FRAME_COUNT;
        cfg_data = '0;
        in_valid = 1'b0;
        page = '0;
        next_use = '0;
        errors = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        clear_page_table();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_fifo_basics();
        test_lru_over_fifo_stamps();
        test_opt_ties_and_shrink();
        test_spare_codes();
        test_random_streams();
        wait_idle();
        if (errors == 0 && pending_outcomes.size() == 0)
            $display("page_replacement_policy test passed");
        else
            $display("page_replacement_policy test failed");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("page_replacement_policy test failed");
        $finish;
    end

endmodule
